>>> rtl/msp_pkg.sv
// Shared types and constants for the MSP v1 request-frame parser.
// No dependencies; used by msp_rx, msp_rel and msp_v1_frame_parser.
package msp_pkg;

    // Header characters of a request frame
    localparam logic [7:0] C_SOF_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] C_SOF_M      = 8'h4D;  // 'M'
    localparam logic [7:0] C_SOF_ARROW  = 8'h3C;  // '<'

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_DOLLAR  = 6'b000010,
        PH_M       = 6'b000100,
        PH_ARROW   = 6'b001000,
        PH_SIZE    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    // Release sequencer states, one-hot
    typedef enum logic [2:0] {
        RL_IDLE = 3'b001,
        RL_READ = 3'b010,
        RL_LOAD = 3'b100
    } t_rel_state;

    // Handoff of a validated frame from parser to release sequencer
    typedef struct packed {
        logic       start;
        logic [7:0] cmd;
        logic [7:0] len;
    } t_frame;

endpackage

>>> rtl/msp_v1_frame_parser.sv
// Top level of the MSP v1 request-frame parser.
// Depends on msp_pkg, msp_buf, msp_rx and msp_rel.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+-------------------------------------------
//   rx in   | i_rx_valid  | o_rx_ready  | i_rx_byte
//   res out | o_res_valid | i_res_ready | o_command_id, o_has_payload,
//           |             |             | o_payload_byte, o_byte_index, o_last_of_frame
//
// Header, size, command and payload bytes are taken one per cycle outside a release.
// A checksum byte that matches starts a release: input is held off while the
// sequencer walks the buffer, each payload result taking a read of the registered read
// port and then a load of the result register; an empty frame takes only the load.
// A stalled result register holds the sequencer in place; input reopens once the
// last result is loaded. Reset is synchronous, active low; the buffer needs no clearing.
module msp_v1_frame_parser #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_command_id,
    output logic       o_has_payload,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_byte_index,
    output logic       o_last_of_frame
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    msp_pkg::t_frame w_frame;
    logic            w_busy;
    logic            w_acc;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic [7:0]      w_wr_data;
    logic            w_rd_en;
    logic [AW-1:0]   w_rd_addr;
    logic [7:0]      w_rd_data;

    // Input is blocked while a frame is being released
    assign o_rx_ready = !w_busy;
    assign w_acc      = i_rx_valid && !w_busy;

    msp_rx #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
        .AW           (AW)
    ) u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (w_acc),
        .i_rx_byte(i_rx_byte),
        .o_frame  (w_frame),
        .o_wr_en  (w_wr_en),
        .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data)
    );

    msp_buf #(
        .DEPTH(PAYLOAD_DEPTH),
        .AW   (AW)
    ) u_buf (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    msp_rel #(
        .AW(AW)
    ) u_rel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame        (w_frame),
        .o_busy         (w_busy),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_command_id   (o_command_id),
        .o_has_payload  (o_has_payload),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_of_frame(o_last_of_frame)
    );

    // Buffer is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("payload buffer written during release");

endmodule

>>> rtl/msp_buf.sv
// Payload buffer: one write port, one registered read port.
// No dependencies; instantiated by msp_v1_frame_parser.
module msp_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/msp_rx.sv
// Byte-level frame parser: header match, size check, XOR checksum, payload write.
// Depends on msp_pkg; writes payload bytes into msp_buf.
module msp_rx #(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int AW            = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  logic [7:0]      i_rx_byte,
    output msp_pkg::t_frame o_frame,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output logic [7:0]      o_wr_data
);

    msp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_len, n_len;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_cmd, n_cmd;

    // Next-state logic for one accepted byte
    always_comb begin
        n_phase       = r_phase;
        n_len         = r_len;
        n_cnt         = r_cnt;
        n_xor         = r_xor;
        n_cmd         = r_cmd;
        o_frame.start = 1'b0;
        o_frame.cmd   = r_cmd;
        o_frame.len   = r_len;
        o_wr_en       = 1'b0;
        if (i_acc) begin
            unique case (r_phase)
                msp_pkg::PH_DOLLAR: begin
                    n_phase = (i_rx_byte == msp_pkg::C_SOF_M) ? msp_pkg::PH_M
                                                              : msp_pkg::PH_IDLE;
                end
                msp_pkg::PH_M: begin
                    n_phase = (i_rx_byte == msp_pkg::C_SOF_ARROW) ? msp_pkg::PH_ARROW
                                                                  : msp_pkg::PH_IDLE;
                end
                msp_pkg::PH_ARROW: begin
                    // oversize frames are ignored
                    if (i_rx_byte > 8'(PAYLOAD_DEPTH)) begin
                        n_phase = msp_pkg::PH_IDLE;
                    end else begin
                        n_len   = i_rx_byte;
                        n_xor   = i_rx_byte;
                        n_cnt   = 8'd0;
                        n_phase = msp_pkg::PH_SIZE;
                    end
                end
                msp_pkg::PH_SIZE: begin
                    n_cmd   = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_phase = msp_pkg::PH_PAYLOAD;
                end
                msp_pkg::PH_PAYLOAD: begin
                    if (r_cnt < r_len) begin
                        n_xor   = r_xor ^ i_rx_byte;
                        o_wr_en = 1'b1;
                        n_cnt   = r_cnt + 8'd1;
                    end else begin
                        // checksum byte: release on match, drop otherwise
                        o_frame.start = (r_xor == i_rx_byte);
                        n_phase       = msp_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == msp_pkg::C_SOF_DOLLAR) ? msp_pkg::PH_DOLLAR
                                                                   : msp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_rx_byte;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= msp_pkg::PH_IDLE;
            r_len   <= 8'd0;
            r_cnt   <= 8'd0;
            r_xor   <= 8'd0;
            r_cmd   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
        end
    end

    // Payload writes stay inside the announced length
    a_wr_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_cnt < r_len && r_phase == msp_pkg::PH_PAYLOAD))
        else $error("payload write beyond frame length");

    // A release only follows a completely received payload
    a_start_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.start |-> (r_cnt == r_len))
        else $error("frame released before payload complete");

    // Length held in range of the buffer
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == msp_pkg::PH_PAYLOAD |-> r_len <= 8'(PAYLOAD_DEPTH))
        else $error("frame length exceeds buffer depth");

endmodule

>>> rtl/msp_rel.sv
// Release sequencer: walks the payload buffer and drives the result register.
// Depends on msp_pkg; reads payload bytes from msp_buf.
module msp_rel #(
    parameter int AW = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  msp_pkg::t_frame i_frame,
    output logic            o_busy,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  logic [7:0]      i_rd_data,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic [7:0]      o_command_id,
    output logic            o_has_payload,
    output logic [7:0]      o_payload_byte,
    output logic [5:0]      o_byte_index,
    output logic            o_last_of_frame
);

    msp_pkg::t_rel_state r_state, n_state;
    logic [7:0] r_k, n_k;
    logic [7:0] r_len, n_len;
    logic [7:0] r_cmd, n_cmd;

    logic       r_out_valid;
    logic [7:0] r_out_cmd;
    logic       r_out_has;
    logic [7:0] r_out_byte;
    logic [5:0] r_out_idx;
    logic       r_out_last;

    logic w_out_free;
    logic w_load;
    logic w_empty;
    logic w_last;

    assign w_out_free = !r_out_valid || i_res_ready;
    assign w_empty    = (r_len == 8'd0);
    assign w_last     = w_empty || (8'(r_k + 8'd1) == r_len);
    assign w_load     = (r_state == msp_pkg::RL_LOAD) && w_out_free;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_len   = r_len;
        n_cmd   = r_cmd;
        unique case (r_state)
            msp_pkg::RL_IDLE: begin
                if (i_frame.start) begin
                    n_len   = i_frame.len;
                    n_cmd   = i_frame.cmd;
                    n_k     = 8'd0;
                    n_state = (i_frame.len == 8'd0) ? msp_pkg::RL_LOAD : msp_pkg::RL_READ;
                end
            end
            msp_pkg::RL_READ: begin
                n_state = msp_pkg::RL_LOAD;
            end
            msp_pkg::RL_LOAD: begin
                if (w_out_free) begin
                    n_k     = r_k + 8'd1;
                    n_state = w_last ? msp_pkg::RL_IDLE : msp_pkg::RL_READ;
                end
            end
            default: begin
                n_state = msp_pkg::RL_IDLE;
            end
        endcase
    end

    assign o_busy    = (r_state != msp_pkg::RL_IDLE);
    assign o_rd_en   = (r_state == msp_pkg::RL_READ);
    assign o_rd_addr = r_k[AW-1:0];

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msp_pkg::RL_IDLE;
            r_k     <= 8'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_cmd <= n_cmd;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_cmd  <= r_cmd;
            r_out_has  <= !w_empty;
            r_out_byte <= w_empty ? 8'd0 : i_rd_data;
            r_out_idx  <= r_k[5:0];
            r_out_last <= w_last;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_command_id    = r_out_cmd;
    assign o_has_payload   = r_out_has;
    assign o_payload_byte  = r_out_byte;
    assign o_byte_index    = r_out_idx;
    assign o_last_of_frame = r_out_last;

    // Every buffer read is followed by the load state
    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == msp_pkg::RL_READ |=> r_state == msp_pkg::RL_LOAD)
        else $error("buffer read not followed by load");

    // Reads stay within the frame
    a_read_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> r_k < r_len)
        else $error("buffer read beyond frame length");

    // A new frame only arrives when the sequencer is idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.start |-> r_state == msp_pkg::RL_IDLE)
        else $error("frame handed over while releasing");

    // An empty frame gives exactly one result at index zero
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_empty |-> r_k == 8'd0)
        else $error("empty frame released more than once");

endmodule

>>> test/msp_v1_frame_parser_chk.sv
`timescale 1ns / 100ps
// Scoreboard for msp_v1_frame_parser: follows every accepted rx item, predicts the
// results released by each good frame and compares accepted results in order.
// Depends on msp_pkg for the header characters and the parser phase type.
module msp_v1_frame_parser_chk #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_command_id,
    input  logic       i_has_payload,
    input  logic [7:0] i_payload_byte,
    input  logic [5:0] i_byte_index,
    input  logic       i_last_of_frame,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count
);

    // One expected result of a released frame
    typedef struct packed {
        logic [7:0] cmd;
        logic       has_data;
        logic [7:0] data;
        logic [5:0] idx;
        logic       last;
    } t_release;

    t_release        release_q[$];
    msp_pkg::t_phase phase;
    logic [7:0]      frame_len;
    logic [7:0]      bytes_seen;
    logic [7:0]      frame_xor;
    logic [7:0]      frame_cmd;
    logic [7:0]      frame_buf [PAYLOAD_DEPTH];

    task automatic report_mismatch(input string msg);
        $display("[%0t] result mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input int idx);
        if (got != want)
            report_mismatch($sformatf("%s of result at index %0d: got 0x%0h, want 0x%0h",
                                      name, idx, got, want));
    endtask

    // Frame parser prediction for one accepted rx item
    task automatic absorb_byte(input logic [7:0] c);
        t_release r;
        case (phase)
            msp_pkg::PH_DOLLAR: begin
                phase = (c == msp_pkg::C_SOF_M) ? msp_pkg::PH_M : msp_pkg::PH_IDLE;
            end
            msp_pkg::PH_M: begin
                phase = (c == msp_pkg::C_SOF_ARROW) ? msp_pkg::PH_ARROW : msp_pkg::PH_IDLE;
            end
            msp_pkg::PH_ARROW: begin
                // size above the buffer depth drops the frame
                if (int'(c) > PAYLOAD_DEPTH) begin
                    phase = msp_pkg::PH_IDLE;
                end else begin
                    frame_len  = c;
                    frame_xor  = c;
                    bytes_seen = '0;
                    phase      = msp_pkg::PH_SIZE;
                end
            end
            msp_pkg::PH_SIZE: begin
                frame_cmd = c;
                frame_xor = frame_xor ^ c;
                phase     = msp_pkg::PH_PAYLOAD;
            end
            msp_pkg::PH_PAYLOAD: begin
                if (bytes_seen < frame_len) begin
                    frame_xor             = frame_xor ^ c;
                    frame_buf[bytes_seen] = c;
                    bytes_seen            = bytes_seen + 8'd1;
                end else begin
                    // checksum byte: release on match, drop silently otherwise
                    if (frame_xor == c) begin
                        if (frame_len == 0) begin
                            r = '{cmd: frame_cmd, has_data: 1'b0, data: 8'h00,
                                  idx: 6'd0, last: 1'b1};
                            release_q.push_back(r);
                        end else begin
                            for (int k = 0; k < int'(frame_len); k++) begin
                                r = '{cmd: frame_cmd, has_data: 1'b1, data: frame_buf[k],
                                      idx: 6'(k), last: (k + 1 == int'(frame_len))};
                                release_q.push_back(r);
                            end
                        end
                    end
                    phase = msp_pkg::PH_IDLE;
                end
            end
            default: begin
                phase = (c == msp_pkg::C_SOF_DOLLAR) ? msp_pkg::PH_DOLLAR : msp_pkg::PH_IDLE;
            end
        endcase
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_release want;
        if (!i_rst_n) begin
            phase      = msp_pkg::PH_IDLE;
            frame_len  = '0;
            bytes_seen = '0;
            frame_xor  = '0;
            frame_cmd  = '0;
            release_q.delete();
        end else begin
            if (i_rx_valid && i_rx_ready)
                absorb_byte(i_rx_byte);
            if (i_res_valid && i_res_ready) begin
                if (release_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result cmd 0x%0h index %0d",
                                              i_command_id, i_byte_index));
                end else begin
                    want = release_q.pop_front();
                    check_field("command_id", i_command_id, want.cmd, want.idx);
                    check_field("has_payload", i_has_payload, want.has_data, want.idx);
                    check_field("payload_byte", i_payload_byte, want.data, want.idx);
                    check_field("byte_index", i_byte_index, want.idx, want.idx);
                    check_field("last_of_frame", i_last_of_frame, want.last, want.idx);
                end
                o_result_count++;
            end
        end
        o_pending = release_q.size();
    end

endmodule

>>> test/msp_v1_frame_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for msp_v1_frame_parser: drives rx items and result back-pressure,
// gives the verdict. Depends on msp_pkg, the RTL and msp_v1_frame_parser_chk.
module msp_v1_frame_parser_tb;

    localparam int PAYLOAD_DEPTH  = 64;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 200;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int TARGET_ITEMS   = 110;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] command_id;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last_of_frame;

    int fail_count;
    int pending;
    int result_count;
    int frame_items;
    int noise_bytes;
    int good_frames;
    int cycles;
    bit tx_calm;
    bit hold_req;

    always #5 clk = ~clk;

    msp_v1_frame_parser #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_command_id   (command_id),
        .o_has_payload  (has_payload),
        .o_payload_byte (payload_byte),
        .o_byte_index   (byte_index),
        .o_last_of_frame(last_of_frame)
    );

    msp_v1_frame_parser_chk #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) i_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .i_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_command_id   (command_id),
        .i_has_payload  (has_payload),
        .i_payload_byte (payload_byte),
        .i_byte_index   (byte_index),
        .i_last_of_frame(last_of_frame),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // One rx item, with a random gap unless the sender is in a calm stretch
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!(rx_valid && rx_ready));
        @(negedge clk);
    endtask

    // Full request frame; bad_sum corrupts the checksum byte
    task automatic send_frame(input int len, input logic [7:0] cmd, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'(len) ^ cmd;
        send_byte(msp_pkg::C_SOF_DOLLAR);
        send_byte(msp_pkg::C_SOF_M);
        send_byte(msp_pkg::C_SOF_ARROW);
        send_byte(8'(len));
        send_byte(cmd);
        for (int k = 0; k < len; k++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
        frame_items += len + 6;
        if (!bad_sum)
            good_frames++;
    endtask

    // Stimulus and verdict
    initial begin
        int pick;
        int len;
        int pos;
        logic [7:0] hdr [3];
        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = 8'h00;
        tx_calm  = 1'b0;
        hold_req = 1'b0;
        hdr[0]   = msp_pkg::C_SOF_DOLLAR;
        hdr[1]   = msp_pkg::C_SOF_M;
        hdr[2]   = msp_pkg::C_SOF_ARROW;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: wrong byte after '$'
        send_byte(msp_pkg::C_SOF_DOLLAR);
        send_byte(8'h58);
        // second '$' aborts and is not taken as a new start
        send_byte(msp_pkg::C_SOF_DOLLAR);
        send_byte(msp_pkg::C_SOF_DOLLAR);
        send_byte(msp_pkg::C_SOF_M);
        // wrong byte after 'M'
        send_byte(msp_pkg::C_SOF_DOLLAR);
        send_byte(msp_pkg::C_SOF_M);
        send_byte(8'h3E);
        // size one above the buffer depth
        send_byte(msp_pkg::C_SOF_DOLLAR);
        send_byte(msp_pkg::C_SOF_M);
        send_byte(msp_pkg::C_SOF_ARROW);
        send_byte(8'(PAYLOAD_DEPTH + 1));
        frame_items += 12;
        // empty frame with all-ones command, then a bad checksum
        send_frame(0, 8'hFF, 1'b0);
        send_frame(1, 8'h00, 1'b1);

        // random: full-depth frame first while the receiver holds off
        hold_req = 1'b1;
        send_frame(PAYLOAD_DEPTH, 8'($urandom), 1'b0);
        while (frame_items + noise_bytes < TARGET_ITEMS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 9);
            if (pick < 8) begin
                // mostly short frames, now and then a long one
                case ($urandom_range(0, 19))
                    0:       len = PAYLOAD_DEPTH;
                    1, 2:    len = $urandom_range(9, PAYLOAD_DEPTH - 1);
                    default: len = $urandom_range(0, 8);
                endcase
                send_frame(len, 8'($urandom), pick == 7);
            end else if (pick == 8) begin
                // line noise
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom));
                    noise_bytes++;
                end
            end else begin
                // broken header, or oversize frame
                pos = $urandom_range(0, 3);
                for (int k = 0; k < 3 && k <= pos; k++)
                    send_byte((k == pos) ? 8'($urandom) : hdr[k]);
                if (pos == 3)
                    send_byte(8'($urandom_range(PAYLOAD_DEPTH + 1, 255)));
                frame_items += (pos == 3) ? 4 : pos + 1;
            end
        end
        rx_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Summary: %0d frame items and %0d noise bytes sent, %0d good frames, %0d results",
                 frame_items, noise_bytes, good_frames, result_count);
        $display("Covered empty and full-depth frames, header and size rejects, bad checksums.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, calm stretches and one long hold-off
    initial begin
        int stall;
        bit held;
        bit rx_calm;
        res_ready = 1'b0;
        held      = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            rx_calm = ((result_count / 24) % 3) == 2;
            stall   = rx_calm ? 0 : $urandom_range(0, 7);
            if (hold_req && !held) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && res_ready));
            @(negedge clk);
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
